>>> src/esc_tpe_pkg.sv
package esc_tpe_pkg;

	// Mode codes of the bank mode registers
	localparam logic [3:0] MODE_PWM50     = 4'd0;
	localparam logic [3:0] MODE_PWM400    = 4'd1;
	localparam logic [3:0] MODE_OS125     = 4'd2;
	localparam logic [3:0] MODE_OS42      = 4'd3;
	localparam logic [3:0] MODE_MULTI     = 4'd4;
	localparam logic [3:0] MODE_DSHOT150  = 4'd5;
	localparam logic [3:0] MODE_DSHOT300  = 4'd6;
	localparam logic [3:0] MODE_DSHOT600  = 4'd7;
	localparam logic [3:0] MODE_DSHOT1200 = 4'd8;

	// Configuration register indexes
	localparam logic [1:0] REG_BANK_ONE_MODE  = 2'd0;
	localparam logic [1:0] REG_BANK_TWO_MODE  = 2'd1;
	localparam logic [1:0] REG_TELEMETRY_MASK = 2'd2;

	// DShot bit times and DShot value gain and offset
	localparam logic [11:0] DSHOT_ONE_TIME  = 12'd53;
	localparam logic [11:0] DSHOT_ZERO_TIME = 12'd26;
	localparam logic [10:0] DIGITAL_GAIN    = 11'd1999;
	localparam logic [10:0] DIGITAL_OFFSET  = 11'd48;

	// Final slot of each word run
	localparam logic [4:0] SLOT_SINGLE_LAST = 5'd0;
	localparam logic [4:0] SLOT_PAIR_LAST   = 5'd1;
	localparam logic [4:0] SLOT_DSHOT_LAST  = 5'd16;

	// Shape of the word run of one item
	typedef enum logic [1:0] {
		KIND_SINGLE,
		KIND_PAIR,
		KIND_DSHOT
	} kind_t;

	// One encoded item, handed from the encoder to the serialiser
	typedef struct packed {
		logic        bank;
		logic [1:0]  lane;
		kind_t       kind;
		logic [11:0] value;   // scaled pulse word (PWM, oneshot, multishot)
		logic [15:0] packet;  // DShot frame, MSB sent first
	} job_t;

endpackage

>>> src/esc_tpe_enc.sv
module esc_tpe_enc #(
	parameter int FRACTION_BITS = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [3:0]          bank_one_mode,
	input  logic [3:0]          bank_two_mode,
	input  logic [7:0]          telemetry_mask,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          channel,
	input  logic signed [15:0]  throttle,
	output logic                job_valid,
	output esc_tpe_pkg::job_t   job,
	input  logic                job_take
);

	localparam int QW = FRACTION_BITS + 1;
	localparam int PW = QW + 11;

	logic                bank;
	logic [1:0]          lane;
	logic [3:0]          mode;
	logic                mode_ok;
	esc_tpe_pkg::kind_t  kind;
	logic [10:0]         gain;
	logic [10:0]         bias;
	logic [31:0]         full32;
	logic [31:0]         raw32;
	logic [31:0]         q32;
	logic [QW-1:0]       q;
	logic [PW-1:0]       prod;
	logic [11:0]         value;
	logic [10:0]         dval;
	logic                tbit;
	logic [11:0]         pkt;
	logic [3:0]          csum;
	logic                accept;
	logic                job_valid_s1;
	esc_tpe_pkg::job_t   job_s1;

	// Bank and mirrored lane of the channel
	assign bank = channel[2];
	assign lane = channel[2] ? ~channel[1:0] : channel[1:0];
	assign mode = bank ? bank_two_mode : bank_one_mode;

	// Gain, bias and word run shape by mode
	always_comb begin
		mode_ok = 1'b1;
		kind    = esc_tpe_pkg::KIND_SINGLE;
		gain    = 11'd1000;
		bias    = 11'd1000;
		unique case (mode)
			esc_tpe_pkg::MODE_PWM50, esc_tpe_pkg::MODE_PWM400: begin
				kind = esc_tpe_pkg::KIND_SINGLE;
				gain = 11'd1000;
				bias = 11'd1000;
			end
			esc_tpe_pkg::MODE_OS125: begin
				kind = esc_tpe_pkg::KIND_PAIR;
				gain = 11'd1049;
				bias = 11'd1049;
			end
			esc_tpe_pkg::MODE_OS42: begin
				kind = esc_tpe_pkg::KIND_PAIR;
				gain = 11'd1175;
				bias = 11'd1175;
			end
			esc_tpe_pkg::MODE_MULTI: begin
				kind = esc_tpe_pkg::KIND_PAIR;
				gain = 11'd1680;
				bias = 11'd420;
			end
			esc_tpe_pkg::MODE_DSHOT150, esc_tpe_pkg::MODE_DSHOT300,
			esc_tpe_pkg::MODE_DSHOT600, esc_tpe_pkg::MODE_DSHOT1200: begin
				kind = esc_tpe_pkg::KIND_DSHOT;
				gain = esc_tpe_pkg::DIGITAL_GAIN;
				bias = esc_tpe_pkg::DIGITAL_OFFSET;
			end
			default: begin
				mode_ok = 1'b0;
			end
		endcase
	end

	// Clamp throttle to 0..full
	assign full32 = 32'd1 << FRACTION_BITS;
	assign raw32  = {16'd0, throttle};
	assign q32    = throttle[15] ? 32'd0 : ((raw32 > full32) ? full32 : raw32);
	assign q      = q32[QW-1:0];

	// Scale: (q * gain) >> FRACTION_BITS, plus bias
	assign prod  = {{11{1'b0}}, q} * {{QW{1'b0}}, gain};
	assign value = {1'b0, prod[FRACTION_BITS+10:FRACTION_BITS]} + {1'b0, bias};

	// DShot frame: value, telemetry bit, xor nibble checksum
	assign dval = (q == '0) ? 11'd0 : value[10:0];
	assign tbit = telemetry_mask[{bank, lane}];
	assign pkt  = {dval, tbit};
	assign csum = pkt[3:0] ^ pkt[7:4] ^ pkt[11:8];

	assign in_ready = !job_valid_s1 || job_take;
	assign accept   = in_valid && in_ready;

	// Job register; items of an unused mode are taken and dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_s1 <= 1'b0;
		end else if (accept) begin
			job_valid_s1 <= mode_ok;
		end else if (job_take) begin
			job_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_s1.bank   <= bank;
			job_s1.lane   <= lane;
			job_s1.kind   <= kind;
			job_s1.value  <= value;
			job_s1.packet <= {pkt, csum};
		end
	end

	assign job_valid = job_valid_s1;
	assign job       = job_s1;

endmodule

>>> src/esc_tpe_ser.sv
module esc_tpe_ser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	input  esc_tpe_pkg::job_t  job,
	output logic               job_take,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               out_bank,
	output logic [1:0]         out_lane,
	output logic [4:0]         out_slot,
	output logic [11:0]        out_value,
	output logic               out_last
);

	logic [4:0]  slot_q;
	logic [4:0]  last_slot;
	logic        is_last;
	logic        advance;
	logic [3:0]  bit_idx;
	logic [11:0] word;
	logic        out_valid_q;
	logic        out_bank_q;
	logic [1:0]  out_lane_q;
	logic [4:0]  out_slot_q;
	logic [11:0] out_value_q;
	logic        out_last_q;

	// Final slot of the current job
	always_comb begin
		case (job.kind)
			esc_tpe_pkg::KIND_SINGLE: last_slot = esc_tpe_pkg::SLOT_SINGLE_LAST;
			esc_tpe_pkg::KIND_PAIR:   last_slot = esc_tpe_pkg::SLOT_PAIR_LAST;
			esc_tpe_pkg::KIND_DSHOT:  last_slot = esc_tpe_pkg::SLOT_DSHOT_LAST;
			default:                  last_slot = esc_tpe_pkg::SLOT_SINGLE_LAST;
		endcase
	end

	assign is_last = (slot_q == last_slot);
	assign bit_idx = 4'd15 - slot_q[3:0];

	// Compare word of the current slot
	always_comb begin
		if (is_last && job.kind != esc_tpe_pkg::KIND_SINGLE) begin
			word = 12'd0;
		end else if (job.kind == esc_tpe_pkg::KIND_DSHOT) begin
			word = job.packet[bit_idx] ? esc_tpe_pkg::DSHOT_ONE_TIME
			                           : esc_tpe_pkg::DSHOT_ZERO_TIME;
		end else begin
			word = job.value;
		end
	end

	assign advance  = !out_valid_q || out_ready;
	assign job_take = advance && job_valid && is_last;

	// Slot counter, one word per output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= job_valid;
			if (job_valid) begin
				slot_q <= is_last ? 5'd0 : slot_q + 5'd1;
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (advance && job_valid) begin
			out_bank_q  <= job.bank;
			out_lane_q  <= job.lane;
			out_slot_q  <= slot_q;
			out_value_q <= word;
			out_last_q  <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_bank  = out_bank_q;
	assign out_lane  = out_lane_q;
	assign out_slot  = out_slot_q;
	assign out_value = out_value_q;
	assign out_last  = out_last_q;

endmodule

>>> src/esc_throttle_pulse_encoder_top.sv
// Channel    Direction  Beat carries
// s_*        in         channel, throttle
// m_*        out        bank, lane, slot, compare_value; tlast marks the final word
// cfg_*      in         register index and value (mode one, mode two, telemetry mask)
//
// One compare word leaves per cycle while m_tready is high: an item is one word in
// PWM modes, two in oneshot and multishot modes and seventeen in DShot modes, set
// by the serialiser that walks the slots of the job register. An input beat fills
// the job register and its words the output register; the next input beat is taken
// at the edge that sends the final word, so runs follow with no gap. Reset sets both
// modes to DShot150, the mask to zero; m_tready low holds the output word and input.
module esc_throttle_pulse_encoder_top #(
	parameter int FRACTION_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,     // channel[2:0], throttle[18:3], zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,     // bank[0], lane[2:1], slot[7:3], compare_value[19:8]
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	logic [3:0]         bank_one_mode_q;
	logic [3:0]         bank_two_mode_q;
	logic [7:0]         telemetry_mask_q;
	logic               job_valid;
	esc_tpe_pkg::job_t  job;
	logic               job_take;
	logic               out_bank;
	logic [1:0]         out_lane;
	logic [4:0]         out_slot;
	logic [11:0]        out_value;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_one_mode_q  <= esc_tpe_pkg::MODE_DSHOT150;
			bank_two_mode_q  <= esc_tpe_pkg::MODE_DSHOT150;
			telemetry_mask_q <= 8'd0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				esc_tpe_pkg::REG_BANK_ONE_MODE:  bank_one_mode_q  <= cfg_data[3:0];
				esc_tpe_pkg::REG_BANK_TWO_MODE:  bank_two_mode_q  <= cfg_data[3:0];
				esc_tpe_pkg::REG_TELEMETRY_MASK: telemetry_mask_q <= cfg_data;
				default: ;
			endcase
		end
	end

	esc_tpe_enc #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_enc (
		.clk            (clk),
		.arst_n         (arst_n),
		.bank_one_mode  (bank_one_mode_q),
		.bank_two_mode  (bank_two_mode_q),
		.telemetry_mask (telemetry_mask_q),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.channel        (s_tdata[2:0]),
		.throttle       (s_tdata[18:3]),
		.job_valid      (job_valid),
		.job            (job),
		.job_take       (job_take)
	);

	esc_tpe_ser u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job),
		.job_take  (job_take),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_bank  (out_bank),
		.out_lane  (out_lane),
		.out_slot  (out_slot),
		.out_value (out_value),
		.out_last  (m_tlast)
	);

	assign m_tdata = {4'd0, out_value, out_slot, out_lane, out_bank};

`ifndef SYNTH
	// A run ends only on one of the final slots (0, 1 or 16)
	a_last_slot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> (m_tdata[7:3] == 5'd0 || m_tdata[7:3] == 5'd1 ||
		m_tdata[7:3] == 5'd16))
		else $error("tlast on an unexpected slot");

	// Within a run the next word carries the next slot
	a_slot_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> !m_tvalid ||
		m_tdata[7:3] == $past(m_tdata[7:3]) + 5'd1)
		else $error("slot did not step by one");

	// Middle DShot slots carry a bit time
	a_bit_time: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[7:3] >= 5'd2 && m_tdata[7:3] < 5'd16 |->
		(m_tdata[19:8] == esc_tpe_pkg::DSHOT_ONE_TIME ||
		m_tdata[19:8] == esc_tpe_pkg::DSHOT_ZERO_TIME))
		else $error("DShot slot without a bit time");
`endif

endmodule

>>> tb/esc_throttle_pulse_encoder_top_tb.sv
`timescale 1ns / 1ps

module esc_throttle_pulse_encoder_top_tb;

	localparam int FRAC_BITS = 12;
	localparam int FULL_THROTTLE = 1 << FRAC_BITS;
	localparam int RANDOM_ITEMS = 440;
	localparam int IDLE_PERCENT = 37;
	localparam int SETTLE_CYCLES = 6;
	localparam int DRAIN_LIMIT = 4000;

	// Mode codes with no encoding behind them
	localparam logic [3:0] MODE_UNUSED_LO = 4'd9;
	localparam logic [3:0] MODE_UNUSED_HI = 4'd15;

	// Shape of the word run one input beat causes
	typedef enum logic [1:0] {
		RUN_NONE,
		RUN_ONE,
		RUN_PAIR,
		RUN_DSHOT
	} run_t;

	typedef struct packed {
		logic        bank;
		logic [1:0]  lane;
		logic [4:0]  slot;
		logic [11:0] value;
		logic        last;
	} compare_word_t;

	// Directed row: bank modes and mask in force, the beat, and a hand-worked word
	// (DShot frame or slot 0 value) where one is given
	typedef struct packed {
		logic [3:0]  mode_one;
		logic [3:0]  mode_two;
		logic [7:0]  mask;
		logic [2:0]  ch;
		logic [15:0] thr;
		logic        known;
		logic [15:0] word;
	} directed_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;     // channel[2:0], throttle[18:3], zero fill
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;     // bank[0], lane[2:1], slot[7:3], compare_value[19:8]
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;

	// Shadow of the register file
	logic [3:0] cur_mode_one;
	logic [3:0] cur_mode_two;
	logic [7:0] cur_mask;

	compare_word_t compare_words_due[$];
	compare_word_t seen_word;
	compare_word_t want_word;

	bit calm;
	int fails;
	int beats;
	int ignored_beats;
	int words_checked;
	int settings;

	directed_row_t directed_rows[24] = '{
		'{esc_tpe_pkg::MODE_DSHOT150, esc_tpe_pkg::MODE_DSHOT150,
			8'h00, 3'd0, 16'h0000, 1'b1, 16'h0000},
		'{esc_tpe_pkg::MODE_DSHOT150, esc_tpe_pkg::MODE_DSHOT150,
			8'h00, 3'd7, 16'h1000, 1'b1, 16'hffee},
		'{esc_tpe_pkg::MODE_DSHOT150, esc_tpe_pkg::MODE_DSHOT150,
			8'h00, 3'd3, 16'h7fff, 1'b1, 16'hffee},
		'{esc_tpe_pkg::MODE_DSHOT150, esc_tpe_pkg::MODE_DSHOT150,
			8'h00, 3'd4, 16'h8000, 1'b1, 16'h0000},
		'{esc_tpe_pkg::MODE_DSHOT150, esc_tpe_pkg::MODE_DSHOT150,
			8'h00, 3'd1, 16'h0001, 1'b0, 16'h0000},
		'{esc_tpe_pkg::MODE_DSHOT300, esc_tpe_pkg::MODE_DSHOT600,
			8'hff, 3'd0, 16'h0000, 1'b1, 16'h0011},
		'{esc_tpe_pkg::MODE_DSHOT300, esc_tpe_pkg::MODE_DSHOT600,
			8'hff, 3'd5, 16'hffff, 1'b1, 16'h0011},
		'{esc_tpe_pkg::MODE_DSHOT300, esc_tpe_pkg::MODE_DSHOT600,
			8'hff, 3'd2, 16'h1000, 1'b1, 16'hffff},
		'{esc_tpe_pkg::MODE_DSHOT1200, esc_tpe_pkg::MODE_DSHOT1200,
			8'h5a, 3'd6, 16'h0fff, 1'b0, 16'h0000},
		'{esc_tpe_pkg::MODE_DSHOT1200, esc_tpe_pkg::MODE_DSHOT1200,
			8'h5a, 3'd1, 16'h0800, 1'b0, 16'h0000},
		'{esc_tpe_pkg::MODE_PWM50, esc_tpe_pkg::MODE_PWM400,
			8'h00, 3'd2, 16'h0000, 1'b1, 16'd1000},
		'{esc_tpe_pkg::MODE_PWM50, esc_tpe_pkg::MODE_PWM400,
			8'h00, 3'd6, 16'h1000, 1'b1, 16'd2000},
		'{esc_tpe_pkg::MODE_PWM50, esc_tpe_pkg::MODE_PWM400,
			8'h00, 3'd4, 16'h8001, 1'b1, 16'd1000},
		'{esc_tpe_pkg::MODE_OS125, esc_tpe_pkg::MODE_OS42,
			8'h00, 3'd0, 16'h1000, 1'b1, 16'd2098},
		'{esc_tpe_pkg::MODE_OS125, esc_tpe_pkg::MODE_OS42,
			8'h00, 3'd7, 16'h0000, 1'b1, 16'd1175},
		'{esc_tpe_pkg::MODE_OS42, esc_tpe_pkg::MODE_OS125,
			8'h00, 3'd1, 16'h1000, 1'b1, 16'd2350},
		'{esc_tpe_pkg::MODE_OS42, esc_tpe_pkg::MODE_OS125,
			8'h00, 3'd5, 16'h0000, 1'b1, 16'd1049},
		'{esc_tpe_pkg::MODE_MULTI, esc_tpe_pkg::MODE_MULTI,
			8'ha5, 3'd3, 16'h0000, 1'b1, 16'd420},
		'{esc_tpe_pkg::MODE_MULTI, esc_tpe_pkg::MODE_MULTI,
			8'ha5, 3'd4, 16'h1000, 1'b1, 16'd2100},
		'{esc_tpe_pkg::MODE_MULTI, esc_tpe_pkg::MODE_MULTI,
			8'ha5, 3'd2, 16'h0abc, 1'b0, 16'h0000},
		'{MODE_UNUSED_LO, MODE_UNUSED_HI, 8'h00, 3'd0, 16'h1000, 1'b1, 16'h0000},
		'{MODE_UNUSED_LO, MODE_UNUSED_HI, 8'h00, 3'd7, 16'h1000, 1'b1, 16'h0000},
		'{MODE_UNUSED_HI, esc_tpe_pkg::MODE_PWM50,
			8'hff, 3'd1, 16'h0000, 1'b1, 16'h0000},
		'{MODE_UNUSED_HI, esc_tpe_pkg::MODE_PWM50,
			8'hff, 3'd4, 16'h1000, 1'b1, 16'd2000}
	};

	esc_throttle_pulse_encoder_top #(
		.FRACTION_BITS(FRAC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// 12 ns clock
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Channels 4-7 take the lanes in reverse order
	function automatic logic [1:0] lane_of(input logic [2:0] ch);
		return ch[2] ? ~ch[1:0] : ch[1:0];
	endfunction

	function automatic run_t pulse_run(input logic [3:0] mode);
		case (mode)
			esc_tpe_pkg::MODE_PWM50, esc_tpe_pkg::MODE_PWM400: return RUN_ONE;
			esc_tpe_pkg::MODE_OS125, esc_tpe_pkg::MODE_OS42,
			esc_tpe_pkg::MODE_MULTI: return RUN_PAIR;
			esc_tpe_pkg::MODE_DSHOT150, esc_tpe_pkg::MODE_DSHOT300,
			esc_tpe_pkg::MODE_DSHOT600, esc_tpe_pkg::MODE_DSHOT1200: return RUN_DSHOT;
			default: return RUN_NONE;
		endcase
	endfunction

	// Slot 0 pulse width for the analogue modes, or the 16-bit DShot frame
	function automatic logic [15:0] encode_pulse(input logic [2:0] ch, input logic [15:0] thr);
		int unsigned q;
		int unsigned v;
		logic [3:0]  mode;
		logic [11:0] frame;
		logic        tbit;
		mode = ch[2] ? cur_mode_two : cur_mode_one;
		if (thr[15])
			q = 0;
		else if (thr > FULL_THROTTLE)
			q = FULL_THROTTLE;
		else
			q = thr;
		case (mode)
			esc_tpe_pkg::MODE_PWM50, esc_tpe_pkg::MODE_PWM400:
				return 16'(((q * 1000) >> FRAC_BITS) + 1000);
			esc_tpe_pkg::MODE_OS125: return 16'(((q * 1049) >> FRAC_BITS) + 1049);
			esc_tpe_pkg::MODE_OS42: return 16'(((q * 1175) >> FRAC_BITS) + 1175);
			esc_tpe_pkg::MODE_MULTI: return 16'(((q * 1680) >> FRAC_BITS) + 420);
			esc_tpe_pkg::MODE_DSHOT150, esc_tpe_pkg::MODE_DSHOT300,
			esc_tpe_pkg::MODE_DSHOT600, esc_tpe_pkg::MODE_DSHOT1200: begin
				// zero throttle stays a zero command, otherwise offset past the specials
				v = (q == 0) ? 0 : (((q * esc_tpe_pkg::DIGITAL_GAIN) >> FRAC_BITS) +
					esc_tpe_pkg::DIGITAL_OFFSET);
				tbit = cur_mask[{ch[2], lane_of(ch)}];
				frame = {v[10:0], tbit};
				return {frame, frame[3:0] ^ frame[7:4] ^ frame[11:8]};
			end
			default: return 16'h0000;
		endcase
	endfunction

	function automatic void queue_compare_words(input logic [2:0] ch, input run_t run,
			input logic [15:0] word);
		compare_word_t w;
		w.bank = ch[2];
		w.lane = lane_of(ch);
		w.last = 1'b0;
		case (run)
			RUN_ONE: begin
				w.slot = esc_tpe_pkg::SLOT_SINGLE_LAST;
				w.value = word[11:0];
				w.last = 1'b1;
				compare_words_due.push_back(w);
			end
			RUN_PAIR: begin
				w.slot = 5'd0;
				w.value = word[11:0];
				compare_words_due.push_back(w);
				w.slot = esc_tpe_pkg::SLOT_PAIR_LAST;
				w.value = 12'd0;
				w.last = 1'b1;
				compare_words_due.push_back(w);
			end
			RUN_DSHOT: begin
				// frame goes out MSB first, one bit time per slot
				for (int i = 0; i < 16; i++) begin
					w.slot = 5'(i);
					w.value = word[15 - i] ? esc_tpe_pkg::DSHOT_ONE_TIME
					                       : esc_tpe_pkg::DSHOT_ZERO_TIME;
					compare_words_due.push_back(w);
				end
				w.slot = esc_tpe_pkg::SLOT_DSHOT_LAST;
				w.value = 12'd0;
				w.last = 1'b1;
				compare_words_due.push_back(w);
			end
			default: ;
		endcase
	endfunction

	// Input beat with a random gap ahead unless calm; expectations queued on acceptance
	task automatic send_item(input logic [2:0] ch, input logic [15:0] thr, input logic known,
			input logic [15:0] word);
		run_t run;
		if (!calm) begin
			while ($urandom_range(0, 99) < IDLE_PERCENT) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'b0, thr, ch};
		do @(posedge clk); while (!s_tready);
		run = pulse_run(ch[2] ? cur_mode_two : cur_mode_one);
		queue_compare_words(ch, run, known ? word : encode_pulse(ch, thr));
		beats++;
		if (run == RUN_NONE)
			ignored_beats++;
	endtask

	// Stop sending, wait for every due word, then let ignored beats clear the pipe
	task automatic settle_out();
		int waited;
		waited = 0;
		s_tvalid <= 1'b0;
		while (compare_words_due.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (compare_words_due.size() != 0) begin
			$error("%0d compare words never arrived", compare_words_due.size());
			fails++;
			compare_words_due.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all three registers back to back, only while the block is idle
	task automatic set_config(input logic [3:0] m1, input logic [3:0] m2, input logic [7:0] mask);
		logic [1:0] idxs [3];
		logic [7:0] vals [3];
		idxs[0] = esc_tpe_pkg::REG_BANK_ONE_MODE;
		idxs[1] = esc_tpe_pkg::REG_BANK_TWO_MODE;
		idxs[2] = esc_tpe_pkg::REG_TELEMETRY_MASK;
		vals[0] = {4'h0, m1};
		vals[1] = {4'h0, m2};
		vals[2] = mask;
		for (int k = 0; k < 3; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idxs[k];
			cfg_data <= vals[k];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		cur_mode_one = m1;
		cur_mode_two = m2;
		cur_mask = mask;
		settings++;
	endtask

	// Output back-pressure
	always @(posedge clk) begin
		m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
	end

	// Output check against the oldest due word
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen_word = '{m_tdata[0], m_tdata[2:1], m_tdata[7:3], m_tdata[19:8], m_tlast};
			if (compare_words_due.size() == 0) begin
				$error("compare word with nothing due: bank %0d lane %0d slot %0d value %0d",
					seen_word.bank, seen_word.lane, seen_word.slot, seen_word.value);
				fails++;
			end else begin
				want_word = compare_words_due.pop_front();
				words_checked++;
				if (seen_word.bank !== want_word.bank) begin
					$error("bank: expected %0d, got %0d", want_word.bank, seen_word.bank);
					fails++;
				end
				if (seen_word.lane !== want_word.lane) begin
					$error("lane: expected %0d, got %0d", want_word.lane, seen_word.lane);
					fails++;
				end
				if (seen_word.slot !== want_word.slot) begin
					$error("slot: expected %0d, got %0d", want_word.slot, seen_word.slot);
					fails++;
				end
				if (seen_word.value !== want_word.value) begin
					$error("compare_value: expected %0d, got %0d (slot %0d)",
						want_word.value, seen_word.value, want_word.slot);
					fails++;
				end
				if (seen_word.last !== want_word.last) begin
					$error("last: expected %0d, got %0d (slot %0d)",
						want_word.last, seen_word.last, want_word.slot);
					fails++;
				end
			end
		end
	end

	// Hard stop
	initial begin
		#5_000_000;
		$display("esc_throttle_pulse_encoder_top_tb NOT OK");
		$finish;
	end

	initial begin
		int useful;
		int phase;
		int len;
		logic [2:0]  ch;
		logic [15:0] thr;
		logic [3:0]  m1;
		logic [3:0]  m2;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = esc_tpe_pkg::REG_BANK_ONE_MODE;
		cfg_data = '0;
		calm = 1'b0;
		fails = 0;
		beats = 0;
		ignored_beats = 0;
		words_checked = 0;
		settings = 1;
		cur_mode_one = esc_tpe_pkg::MODE_DSHOT150;
		cur_mode_two = esc_tpe_pkg::MODE_DSHOT150;
		cur_mask = 8'h00;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows; registers rewritten whenever a row asks for new settings
		foreach (directed_rows[r]) begin
			if (directed_rows[r].mode_one != cur_mode_one ||
					directed_rows[r].mode_two != cur_mode_two ||
					directed_rows[r].mask != cur_mask) begin
				settle_out();
				set_config(directed_rows[r].mode_one, directed_rows[r].mode_two,
					directed_rows[r].mask);
			end
			send_item(directed_rows[r].ch, directed_rows[r].thr, directed_rows[r].known,
				directed_rows[r].word);
		end

		// Random phases, each under fresh settings; phase 2 runs with no idling
		useful = 0;
		phase = 0;
		while (useful < RANDOM_ITEMS) begin
			settle_out();
			m1 = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
			m2 = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
			set_config(m1, m2, 8'($urandom_range(0, 255)));
			calm = (phase == 2);
			len = $urandom_range(30, 70);
			repeat (len) begin
				ch = 3'($urandom_range(0, 7));
				case ($urandom_range(0, 9))
					0: thr = 16'h0000;
					1: thr = 16'(FULL_THROTTLE);
					2: thr = 16'($urandom_range(0, 65535));
					3: thr = 16'($urandom_range(32768, 65535));
					4: thr = 16'($urandom_range(FULL_THROTTLE + 1, 32767));
					default: thr = 16'($urandom_range(0, FULL_THROTTLE));
				endcase
				if (pulse_run(ch[2] ? cur_mode_two : cur_mode_one) != RUN_NONE)
					useful++;
				send_item(ch, thr, 1'b0, 16'h0000);
			end
			calm = 1'b0;
			phase++;
		end
		settle_out();

		$display("Covered %0d input beats (%0d under unused modes) across %0d register settings,",
			beats, ignored_beats, settings);
		$display("checking %0d compare words with %0d mismatches", words_checked, fails);
		if (fails == 0)
			$display("esc_throttle_pulse_encoder_top_tb OK");
		else
			$display("esc_throttle_pulse_encoder_top_tb NOT OK");
		$finish;
	end

endmodule
